FILE: design/sfb_pkg.sv
// Shared types, codes and pipeline depths for the shell fiber basis frame core.
package sfb_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int UNI_DEPTH  = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec32_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec64_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    KIND_POINT,
    KIND_LX,
    KIND_LY,
    KIND_LZ
  } kind_t;

  // Per-node payload carried alongside the vector being normalized.
  typedef struct packed {
    vec32_t pt;
    vec32_t lz;
    vec32_t ly;
    axis_t  axis;
    logic   deg;
  } side_t;

endpackage

FILE: design/sfb_unitize.sv
// Pipelined vector normalization to Q2.30: magnitude, scale, square sum, root, divide.
module sfb_unitize
  import sfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  vec64_t in_vec,
  input  side_t  in_side,
  output logic   out_valid,
  output vec32_t out_vec,
  output side_t  out_side
);

  logic signed [63:0] vin [3];
  assign vin[0] = in_vec.x;
  assign vin[1] = in_vec.y;
  assign vin[2] = in_vec.z;

  logic [UNI_DEPTH-1:0] vld_r;
  side_t                side_sh_r [UNI_DEPTH];
  logic [3:0]           flag_sh_r [UNI_DEPTH];

  logic [2:0][63:0] a0_r, a1_r, a2_r;
  logic [63:0]      m1_r;
  logic [5:0]       pos2_r;
  logic [2:0][30:0] an3_r, an4_r;
  logic [2:0][61:0] sq4_r;
  logic             zero_c;
  logic [63:0]      m_c;
  logic [5:0]       pos_c;
  logic [2:0][30:0] an_nxt;

  logic [63:0]      sq_sin_r [SQRT_STEPS+1];
  logic [35:0]      sq_rem_r [SQRT_STEPS+1];
  logic [31:0]      sq_rt_r  [SQRT_STEPS+1];
  logic [2:0][30:0] sq_an_r  [SQRT_STEPS+1];

  logic [2:0][31:0] dv_rem_r [DIV_STEPS+1];
  logic [2:0][30:0] dv_low_r [DIV_STEPS+1];
  logic [2:0][30:0] dv_q_r   [DIV_STEPS+1];
  logic [31:0]      dv_d_r   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[UNI_DEPTH-2:0], in_valid};
    end
  end

  // Side data and flags {zero, signs}; the zero flag joins after the max stage.
  always_ff @(posedge clk) begin
    side_t side1;
    if (adv) begin
      side1        = side_sh_r[0];
      side1.deg    = side_sh_r[0].deg | zero_c;
      side_sh_r[0] <= in_side;
      flag_sh_r[0] <= {1'b0, vin[2][63], vin[1][63], vin[0][63]};
      side_sh_r[1] <= side1;
      flag_sh_r[1] <= {zero_c, flag_sh_r[0][2:0]};
      for (int k = 2; k < UNI_DEPTH; k++) begin
        side_sh_r[k] <= side_sh_r[k-1];
        flag_sh_r[k] <= flag_sh_r[k-1];
      end
    end
  end

  always_comb begin
    m_c = a0_r[0];
    if (a0_r[1] > m_c) m_c = a0_r[1];
    if (a0_r[2] > m_c) m_c = a0_r[2];
    zero_c = (m_c == 64'd0);
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 64; i++) begin
      if (m1_r[i]) pos_c = 6'(i);
    end
  end

  // Bring the largest magnitude into [2^30, 2^31).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2_r > 6'd30) an_nxt[i] = 31'(a2_r[i] >> (pos2_r - 6'd30));
      else                an_nxt[i] = 31'(a2_r[i] << (6'd30 - pos2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a0_r[i]  <= vin[i][63] ? -vin[i] : vin[i];
        sq4_r[i] <= 62'(an3_r[i]) * 62'(an3_r[i]);
      end
      a1_r   <= a0_r;
      m1_r   <= m_c;
      a2_r   <= a1_r;
      pos2_r <= pos_c;
      an3_r  <= an_nxt;
      an4_r  <= an3_r;
      sq_sin_r[0] <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
      sq_rem_r[0] <= '0;
      sq_rt_r[0]  <= '0;
      sq_an_r[0]  <= an4_r;
    end
  end

  // Restoring square root, one root bit per stage.
  for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
    logic [35:0] rem_t, trial;
    assign rem_t = {sq_rem_r[j-1][33:0], sq_sin_r[j-1][63:62]};
    assign trial = {2'b00, sq_rt_r[j-1], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_t >= trial) begin
          sq_rem_r[j] <= rem_t - trial;
          sq_rt_r[j]  <= {sq_rt_r[j-1][30:0], 1'b1};
        end else begin
          sq_rem_r[j] <= rem_t;
          sq_rt_r[j]  <= {sq_rt_r[j-1][30:0], 1'b0};
        end
        sq_sin_r[j] <= {sq_sin_r[j-1][61:0], 2'b00};
        sq_an_r[j]  <= sq_an_r[j-1];
      end
    end
  end

  // Dividend a*2^30 + r/2; its top bits are already below the divisor.
  always_ff @(posedge clk) begin
    logic [61:0] num;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num = {1'b0, sq_an_r[SQRT_STEPS][i], 30'd0} + 62'(sq_rt_r[SQRT_STEPS] >> 1);
        dv_rem_r[0][i] <= {1'b0, num[61:31]};
        dv_low_r[0][i] <= num[30:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_d_r[0] <= sq_rt_r[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [2:0][32:0] rt_t;
    always_comb begin
      for (int i = 0; i < 3; i++) rt_t[i] = {dv_rem_r[j-1][i], dv_low_r[j-1][i][30]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (rt_t[i] >= {1'b0, dv_d_r[j-1]}) begin
            dv_rem_r[j][i] <= 32'(rt_t[i] - {1'b0, dv_d_r[j-1]});
            dv_q_r[j][i]   <= {dv_q_r[j-1][i][29:0], 1'b1};
          end else begin
            dv_rem_r[j][i] <= rt_t[i][31:0];
            dv_q_r[j][i]   <= {dv_q_r[j-1][i][29:0], 1'b0};
          end
          dv_low_r[j][i] <= {dv_low_r[j-1][i][29:0], 1'b0};
        end
        dv_d_r[j] <= dv_d_r[j-1];
      end
    end
  end

  // Apply signs; a zero vector gives zero.
  always_ff @(posedge clk) begin
    logic [3:0]        fl;
    logic [2:0][31:0]  q;
    if (adv) begin
      fl = flag_sh_r[UNI_DEPTH-2];
      for (int i = 0; i < 3; i++) begin
        q[i] = {1'b0, dv_q_r[DIV_STEPS][i]};
        if (fl[3])      q[i] = '0;
        else if (fl[i]) q[i] = -q[i];
      end
      out_vec.x <= q[0];
      out_vec.y <= q[1];
      out_vec.z <= q[2];
    end
  end

  assign out_valid = vld_r[UNI_DEPTH-1];
  assign out_side  = side_sh_r[UNI_DEPTH-1];

endmodule

FILE: design/shell_fiber_basis_frame_core.sv
// Top level of the shell fiber basis frame core: node pipeline and result serializer.
//
// Usage: one node (bottom and top surface points, Q16.16) is transferred on the
// in_ channel; four results follow on the out_ channel in order: the lamina
// reference point (Q16.16), then local x, local y and local z unit vectors
// (Q2.30). out_last marks the fourth result; out_degenerate is set on all four
// when the fiber or a cross product has zero length.
// A node's first result is followed by the other three back to back when not
// stalled. The path is two input stages, three 71-stage normalization pipelines
// (32 root steps and 31 divide steps each) and three cross-product stages,
// ending in a four-result serializer. Each node holds the result channel for
// four transfers, one result per transfer; the pipeline itself takes a node
// every cycle while in_stall is low.
// cfg_wr_en writes zeta_weight (Q1.16) from cfg_wr_data; write it only when idle.
// Reset (synchronous, rst_n low) clears all valid bits, the serializer and
// zeta_weight. While out_stall is high the serializer holds its result; once
// the pipeline tail holds a node as well, in_stall rises and every stage holds.
module shell_fiber_basis_frame_core
  import sfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic signed [17:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_bottom_x,
  input  logic signed [31:0] in_bottom_y,
  input  logic signed [31:0] in_bottom_z,
  input  logic signed [31:0] in_top_x,
  input  logic signed [31:0] in_top_y,
  input  logic signed [31:0] in_top_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_vector_kind,
  output logic signed [31:0] out_comp_x,
  output logic signed [31:0] out_comp_y,
  output logic signed [31:0] out_comp_z,
  output logic               out_degenerate,
  output logic               out_last
);

  logic signed [17:0] zeta_r;
  logic               adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zeta_r <= '0;
    end else if (cfg_wr_en) begin
      zeta_r <= cfg_wr_data;
    end
  end

  // Stage 1: blend products and fiber difference.
  logic signed [31:0] bot [3];
  logic signed [31:0] top [3];
  assign bot[0] = in_bottom_x;
  assign bot[1] = in_bottom_y;
  assign bot[2] = in_bottom_z;
  assign top[0] = in_top_x;
  assign top[1] = in_top_y;
  assign top[2] = in_top_z;

  logic signed [18:0] wt, wb;
  assign wt = 19'sd65536 + 19'(zeta_r);
  assign wb = 19'sd65536 - 19'(zeta_r);

  logic               v1_r;
  logic signed [50:0] ptop1_r [3];
  logic signed [50:0] pbot1_r [3];
  logic signed [32:0] d1_r    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ptop1_r[i] <= 51'(top[i]) * 51'(wt);
        pbot1_r[i] <= 51'(bot[i]) * 51'(wb);
        d1_r[i]    <= 33'(top[i]) - 33'(bot[i]);
      end
    end
  end

  // Stage 2: round, halve and saturate the point; pick the helper axis.
  logic               v2_r;
  logic signed [32:0] d2_r [3];
  side_t              side2_r;
  logic signed [31:0] pt_nxt [3];
  axis_t              axis_nxt;

  always_comb begin
    logic signed [53:0] acc;
    logic signed [53:0] sh;
    logic [32:0]        ax, ay, az, t;
    for (int i = 0; i < 3; i++) begin
      acc = 54'(ptop1_r[i]) + 54'(pbot1_r[i]) + 54'sd65536;
      sh  = acc >>> 17;
      if (sh > 54'sd2147483647)       pt_nxt[i] = 32'sh7FFFFFFF;
      else if (sh < -54'sd2147483648) pt_nxt[i] = 32'sh80000000;
      else                            pt_nxt[i] = 32'(sh);
    end
    ax = d1_r[0][32] ? 33'(-d1_r[0]) : 33'(d1_r[0]);
    ay = d1_r[1][32] ? 33'(-d1_r[1]) : 33'(d1_r[1]);
    az = d1_r[2][32] ? 33'(-d1_r[2]) : 33'(d1_r[2]);
    axis_nxt = AXIS_X;
    t = az;
    if (ax > az) begin
      t = ax;
      axis_nxt = AXIS_Y;
    end
    if (ay > t) axis_nxt = AXIS_Z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    side_t s2;
    if (adv) begin
      s2      = '0;
      s2.pt.x = pt_nxt[0];
      s2.pt.y = pt_nxt[1];
      s2.pt.z = pt_nxt[2];
      s2.axis = axis_nxt;
      d2_r    <= d1_r;
      side2_r <= s2;
    end
  end

  // Local z: normalize the fiber.
  vec64_t va_in;
  assign va_in.x = 64'(d2_r[0]);
  assign va_in.y = 64'(d2_r[1]);
  assign va_in.z = 64'(d2_r[2]);

  logic   va_valid;
  vec32_t va_vec;
  side_t  va_side;

  sfb_unitize u_unit_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v2_r),
    .in_vec    (va_in),
    .in_side   (side2_r),
    .out_valid (va_valid),
    .out_vec   (va_vec),
    .out_side  (va_side)
  );

  // Stage 3: z cross helper axis.
  logic   v3_r;
  vec64_t c3_r;
  side_t  side3_r;
  vec64_t c3_nxt;

  always_comb begin
    c3_nxt = '0;
    case (va_side.axis)
      AXIS_X: begin
        c3_nxt.y = 64'(va_vec.z);
        c3_nxt.z = -64'(va_vec.y);
      end
      AXIS_Y: begin
        c3_nxt.x = -64'(va_vec.z);
        c3_nxt.z = 64'(va_vec.x);
      end
      AXIS_Z: begin
        c3_nxt.x = 64'(va_vec.y);
        c3_nxt.y = -64'(va_vec.x);
      end
      default: c3_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= va_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_t s3;
    if (adv) begin
      s3      = va_side;
      s3.lz   = va_vec;
      c3_r    <= c3_nxt;
      side3_r <= s3;
    end
  end

  // Local y: normalize that cross product.
  logic   vb_valid;
  vec32_t vb_vec;
  side_t  vb_side;

  sfb_unitize u_unit_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v3_r),
    .in_vec    (c3_r),
    .in_side   (side3_r),
    .out_valid (vb_valid),
    .out_vec   (vb_vec),
    .out_side  (vb_side)
  );

  // Stages 4 and 5: y cross z, products then differences.
  logic               v4_r, v5_r;
  logic signed [63:0] p4_r [6];
  side_t              side4_r, side5_r;
  vec64_t             c5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vb_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    side_t s4;
    if (adv) begin
      s4         = vb_side;
      s4.ly      = vb_vec;
      p4_r[0]    <= 64'(vb_vec.y) * 64'(vb_side.lz.z);
      p4_r[1]    <= 64'(vb_vec.z) * 64'(vb_side.lz.y);
      p4_r[2]    <= 64'(vb_vec.z) * 64'(vb_side.lz.x);
      p4_r[3]    <= 64'(vb_vec.x) * 64'(vb_side.lz.z);
      p4_r[4]    <= 64'(vb_vec.x) * 64'(vb_side.lz.y);
      p4_r[5]    <= 64'(vb_vec.y) * 64'(vb_side.lz.x);
      side4_r    <= s4;
      c5_r.x     <= p4_r[0] - p4_r[1];
      c5_r.y     <= p4_r[2] - p4_r[3];
      c5_r.z     <= p4_r[4] - p4_r[5];
      side5_r    <= side4_r;
    end
  end

  // Local x: normalize y cross z.
  logic   vc_valid;
  vec32_t vc_vec;
  side_t  vc_side;

  sfb_unitize u_unit_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v5_r),
    .in_vec    (c5_r),
    .in_side   (side5_r),
    .out_valid (vc_valid),
    .out_vec   (vc_vec),
    .out_side  (vc_side)
  );

  // Serializer: hold one node and send its four results in order.
  logic   ser_v_r;
  kind_t  ser_kind_r;
  vec32_t ser_pt_r, ser_lx_r, ser_ly_r, ser_lz_r;
  logic   ser_deg_r;
  logic   ser_done, ser_load;

  assign ser_done = ser_v_r && !out_stall && (ser_kind_r == KIND_LZ);
  assign ser_load = vc_valid && (!ser_v_r || ser_done);
  // Advance the whole pipeline unless its tail node has nowhere to go.
  assign adv      = !vc_valid || !ser_v_r || ser_done;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r    <= 1'b0;
      ser_kind_r <= KIND_POINT;
    end else if (ser_load) begin
      ser_v_r    <= 1'b1;
      ser_kind_r <= KIND_POINT;
    end else if (ser_v_r && !out_stall) begin
      if (ser_kind_r == KIND_LZ) ser_v_r <= 1'b0;
      else                       ser_kind_r <= kind_t'(ser_kind_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_pt_r  <= vc_side.pt;
      ser_lx_r  <= vc_vec;
      ser_ly_r  <= vc_side.ly;
      ser_lz_r  <= vc_side.lz;
      ser_deg_r <= vc_side.deg;
    end
  end

  vec32_t out_sel;
  always_comb begin
    case (ser_kind_r)
      KIND_POINT: out_sel = ser_pt_r;
      KIND_LX:    out_sel = ser_lx_r;
      KIND_LY:    out_sel = ser_ly_r;
      KIND_LZ:    out_sel = ser_lz_r;
      default:    out_sel = ser_pt_r;
    endcase
  end

  assign out_valid       = ser_v_r;
  assign out_vector_kind = ser_kind_r;
  assign out_comp_x      = out_sel.x;
  assign out_comp_y      = out_sel.y;
  assign out_comp_z      = out_sel.z;
  assign out_degenerate  = ser_deg_r;
  assign out_last        = (ser_kind_r == KIND_LZ);

  // A node's results come back to back in kind order once started.
  a_kind_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && out_vector_kind == $past(out_vector_kind) + 2'd1))
    else $error("result sequence broken within a node");

  // The degenerate flag is common to all four results of a node.
  a_deg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (out_degenerate == $past(out_degenerate)))
    else $error("degenerate flag changed within a node");

  // A non-degenerate unit vector is never all zero.
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate && out_vector_kind != KIND_POINT) |->
      (out_comp_x != 32'sd0 || out_comp_y != 32'sd0 || out_comp_z != 32'sd0))
    else $error("zero unit vector without degenerate flag");

  // Input stalls only when the tail node cannot move into the serializer.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vc_valid && ser_v_r && !ser_done))
    else $error("pipeline held without a blocked tail");

endmodule

FILE: bench/tb_top.sv
// Testbench for the shell fiber basis frame core with a local result predictor.
module tb_top
  import sfb_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic signed [17:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_bottom_x = '0, in_bottom_y = '0, in_bottom_z = '0;
  logic signed [31:0] in_top_x = '0, in_top_y = '0, in_top_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_vector_kind;
  logic signed [31:0] out_comp_x, out_comp_y, out_comp_z;
  logic               out_degenerate, out_last;

  // One expected result of a node.
  typedef struct {
    kind_t       kind;
    logic [31:0] cx, cy, cz;
    logic        deg, last;
  } frame_row_t;

  frame_row_t        frame_q[$];
  logic signed [17:0] zeta;
  int                errors = 0;
  longint            cycle = 0;
  bit                quiet = 0;    // when set, neither side idles

  localparam longint CYCLE_LIMIT = 400000;

  shell_fiber_basis_frame_core dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall,
    .in_bottom_x, .in_bottom_y, .in_bottom_z,
    .in_top_x, .in_top_y, .in_top_z,
    .out_valid, .out_stall, .out_vector_kind,
    .out_comp_x, .out_comp_y, .out_comp_z,
    .out_degenerate, .out_last
  );

  always #6 clk = ~clk;

  // Bound the run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale to Q2.30 unit length; zero vector returns 0 and a zero result.
  function automatic bit to_unit(input longint v[3], output longint u[3]);
    longint unsigned a[3], m, s, r, q;
    for (int i = 0; i < 3; i++) a[i] = mag64(v[i]);
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m == 0) begin
      u = '{0, 0, 0};
      return 0;
    end
    while (m >= (64'd1 << 31)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    r = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (r >> 1)) / r;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Work out the four results of one node and queue them.
  function automatic void predict_frame(input logic signed [31:0] b[3],
                                        input logic signed [31:0] t[3]);
    longint pt[3], d[3], lz[3], ly[3], lx[3], c[3], acc, wt, wb;
    longint unsigned ax, ay, az, th;
    axis_t axis;
    bit ok;
    frame_row_t row;
    ok = 1;
    wt = 65536 + longint'(zeta);
    wb = 65536 - longint'(zeta);
    for (int i = 0; i < 3; i++) begin
      acc = longint'(t[i]) * wt + longint'(b[i]) * wb + 65536;
      pt[i] = sat32(acc >>> 17);
      d[i] = longint'(t[i]) - longint'(b[i]);
    end
    if (!to_unit(d, lz)) ok = 0;
    ax = mag64(d[0]); ay = mag64(d[1]); az = mag64(d[2]);
    axis = AXIS_X; th = az;
    if (ax > az) begin th = ax; axis = AXIS_Y; end
    if (ay > th) axis = AXIS_Z;
    case (axis)
      AXIS_X: c = '{0, lz[2], -lz[1]};
      AXIS_Y: c = '{-lz[2], 0, lz[0]};
      default: c = '{lz[1], -lz[0], 0};
    endcase
    if (!to_unit(c, ly)) ok = 0;
    c[0] = ly[1] * lz[2] - ly[2] * lz[1];
    c[1] = ly[2] * lz[0] - ly[0] * lz[2];
    c[2] = ly[0] * lz[1] - ly[1] * lz[0];
    if (!to_unit(c, lx)) ok = 0;
    row.deg = !ok;
    row.last = 0;
    row.kind = KIND_POINT;
    row.cx = 32'(pt[0]); row.cy = 32'(pt[1]); row.cz = 32'(pt[2]);
    frame_q.push_back(row);
    row.kind = KIND_LX;
    row.cx = 32'(lx[0]); row.cy = 32'(lx[1]); row.cz = 32'(lx[2]);
    frame_q.push_back(row);
    row.kind = KIND_LY;
    row.cx = 32'(ly[0]); row.cy = 32'(ly[1]); row.cz = 32'(ly[2]);
    frame_q.push_back(row);
    row.kind = KIND_LZ;
    row.cx = 32'(lz[0]); row.cy = 32'(lz[1]); row.cz = 32'(lz[2]);
    row.last = 1;
    frame_q.push_back(row);
  endfunction

  // Randomly stall the result side, except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    frame_row_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_vector_kind);
        errors++;
      end else begin
        w = frame_q.pop_front();
        if (out_vector_kind !== w.kind) begin
          $error("vector_kind exp %0d got %0d", w.kind, out_vector_kind); errors++;
        end
        if (out_comp_x !== w.cx) begin
          $error("comp_x exp %h got %h", w.cx, out_comp_x); errors++;
        end
        if (out_comp_y !== w.cy) begin
          $error("comp_y exp %h got %h", w.cy, out_comp_y); errors++;
        end
        if (out_comp_z !== w.cz) begin
          $error("comp_z exp %h got %h", w.cz, out_comp_z); errors++;
        end
        if (out_degenerate !== w.deg) begin
          $error("degenerate exp %0d got %0d", w.deg, out_degenerate); errors++;
        end
        if (out_last !== w.last) begin
          $error("last exp %0d got %0d", w.last, out_last); errors++;
        end
      end
    end
  end

  // Transfer one node, with an optional random gap first; predict on acceptance.
  // Valid stays high after the transfer until the next gap or drain drops it.
  task automatic send_node(input logic signed [31:0] b[3], input logic signed [31:0] t[3]);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 8);
    end
    in_valid <= 1'b1;
    in_bottom_x <= b[0]; in_bottom_y <= b[1]; in_bottom_z <= b[2];
    in_top_x <= t[0]; in_top_y <= t[1]; in_top_z <= t[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(b, t);
  endtask

  // Drop valid, wait until every expected result has come, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (240) @(posedge clk);
  endtask

  task automatic set_zeta(input logic signed [17:0] z);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= z;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    zeta = z;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      2: return 32'($signed($urandom_range(4000)) - 2000);
      default: return 32'($signed($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  // Extremes, every helper axis, zero fiber and small fibers.
  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7fff_ffff; mn = 32'sh8000_0000;
    send_node('{0, 0, 0}, '{0, 0, 0});                       // zero fiber
    send_node('{5, -7, 9}, '{5, -7, 9});                     // zero fiber, nonzero point
    send_node('{mn, mn, mn}, '{mx, mx, mx});
    send_node('{mx, mx, mx}, '{mn, mn, mn});
    send_node('{mx, mn, mx}, '{mn, mx, mn});
    send_node('{0, 0, 0}, '{0, 0, 65536});                   // helper axis x
    send_node('{0, 0, 0}, '{65536, 0, 0});                   // helper axis y
    send_node('{0, 0, 0}, '{0, 65536, 0});                   // helper axis z
    send_node('{0, 0, 0}, '{1, 1, 1});                       // ties
    send_node('{0, 0, 0}, '{1, 0, 0});
    send_node('{0, 0, 0}, '{0, -1, 0});
    send_node('{0, 0, 0}, '{-3, 2, -1});
    send_node('{100, 200, 300}, '{-400, 500, -600});
    send_node('{mn, 0, 0}, '{mx, 0, 0});
    send_node('{0, mx, 0}, '{0, mn, 1});
    send_node('{-1, -1, -1}, '{0, 0, 0});
  endtask

  task automatic test_random(input int n);
    logic signed [31:0] b[3], t[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        b[i] = rand_coord();
        t[i] = $urandom_range(9) == 0 ? b[i] : rand_coord();   // some axis-aligned fibers
      end
      send_node(b, t);
    end
  endtask

  // Hold off the sender until every result is in, then resume.
  task automatic test_pause();
    test_random(20);
    drain();
    test_random(10);
  endtask

  initial begin
    zeta = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();                     // zeta at reset value
    set_zeta(18'sd65536);  test_directed(); test_random(60);
    set_zeta(-18'sd65536); test_directed(); test_random(60);
    set_zeta(18'sh1ffff);  test_random(30);   // out of range, saturates
    set_zeta(18'sh20000);  test_random(30);
    set_zeta(18'sd32768);  test_pause();
    quiet = 1;
    test_random(80);                     // stretch with no idling
    quiet = 0;
    set_zeta(-18'sd12345); test_random(120);
    drain();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
